### rtl/sfm_pkg.sv
// sorted fragment map package: sizes, operation codes, cell command and entry types
// used by every module of the sorted fragment map, depends on nothing
`timescale 1ns / 1ps

package sfm_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int SIZE_W   = 32;
   localparam int FTYPE_W  = 8;
   localparam int TOTAL_W  = 64;
   localparam int FUNC_W   = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 88;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_EVICT  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_REDUCE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SIZE_W-1:0]  size;
      logic [FTYPE_W-1:0] frag_type;
   } entry_type;

   typedef struct packed {
      logic      compare;
      logic      insert_new;
      logic      set_type;
      logic      remove;
      entry_type data;
   } cell_cmd_type;

endpackage

### rtl/sfm_cell.sv
// sorted fragment map cell: one table entry with its key compare flags
// shifts entries to and from its neighbors, depends on sfm_pkg
`timescale 1ns / 1ps

module sfm_cell (
   input  logic                      clock,
   input  sfm_pkg::cell_cmd_type     cmd,
   input  logic [sfm_pkg::IDX_W-1:0] cell_index,
   input  logic [sfm_pkg::CNT_W-1:0] used_count,
   input  sfm_pkg::entry_type        left_entry,
   input  logic                      left_lt,
   input  sfm_pkg::entry_type        right_entry,
   output sfm_pkg::entry_type        entry,
   output logic                      lt,
   output logic                      eq
);
   import sfm_pkg::*;

   entry_type entry_ff, entry_in;
   logic      lt_ff, lt_in;
   logic      eq_ff, eq_in;
   logic      valid;

   assign valid = CNT_W'(cell_index) < used_count;

   always_comb begin
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      entry_in = entry_ff;
      if (cmd.compare) begin
         lt_in = valid && (entry_ff.key < cmd.data.key);
         eq_in = valid && (entry_ff.key == cmd.data.key);
      end
      if (cmd.insert_new) begin
         if (!lt_ff) begin
            entry_in = left_lt ? cmd.data : left_entry;
         end
      end else if (cmd.remove) begin
         if (!lt_ff) begin
            entry_in = right_entry;
         end
      end else if (cmd.set_type) begin
         if (eq_ff) begin
            entry_in.frag_type = cmd.data.frag_type;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

### rtl/sfm_reduce.sv
// sorted fragment map match reduce: picks the matching entry out of the cell row
// registered or-tree over the match flags, depends on sfm_pkg
`timescale 1ns / 1ps

module sfm_reduce (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [sfm_pkg::CAPACITY-1:0]  eq,
   input  sfm_pkg::entry_type            entries [sfm_pkg::CAPACITY],
   output logic                          found,
   output logic [sfm_pkg::FTYPE_W-1:0]   old_type,
   output logic [sfm_pkg::SIZE_W-1:0]    old_size
);
   import sfm_pkg::*;

   logic               found_ff, found_in;
   logic [FTYPE_W-1:0] old_type_ff, old_type_in;
   logic [SIZE_W-1:0]  old_size_ff, old_size_in;

   always_comb begin
      found_in    = |eq;
      old_type_in = '0;
      old_size_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         old_type_in = old_type_in | (entries[i].frag_type & {FTYPE_W{eq[i]}});
         old_size_in = old_size_in | (entries[i].size & {SIZE_W{eq[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         found_ff    <= found_in;
         old_type_ff <= old_type_in;
         old_size_ff <= old_size_in;
      end
   end

   assign found    = found_ff;
   assign old_type = old_type_ff;
   assign old_size = old_size_ff;

endmodule

### rtl/sorted_fragment_map_core.sv
// sorted fragment map top level: sequencer, cell row, match reduce, totals, result register
// depends on sfm_pkg, sfm_cell and sfm_reduce
`timescale 1ns / 1ps
//
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | tdata offset, fragment_size, fragment_type; tuser func
// rsp     | out | rsp_tvalid/rsp_tready  | tdata hit, stored_type, insert_refused, cached_total,
//         |     |                        | entry_count
//
// an item passes in order through accept, compare in every cell, reduce the match, update the row
// the update cycle waits while an earlier result is still held in the result register
// a new item is taken in the cycle after the update, so one item is finished before the next is taken
// reset (synchronous) empties the table and clears the byte total, entries need no clearing
//
module sorted_fragment_map_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] offset, [63:32] fragment_size, [71:64] fragment_type
   input  logic [sfm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] func
   input  logic [sfm_pkg::FUNC_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] hit, [8:1] stored_type, [9] insert_refused, [73:10] cached_total,
   // [80:74] entry_count, [87:81] zero
   output logic [sfm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import sfm_pkg::*;

   state_type          state_ff, state_in;
   func_type           func_ff;
   entry_type          op_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   cell_cmd_type       cmd;
   entry_type          entries [CAPACITY];
   logic [CAPACITY-1:0] lt_row;
   logic [CAPACITY-1:0] eq_row;
   logic               found;
   logic [FTYPE_W-1:0] old_type;
   logic [SIZE_W-1:0]  old_size;
   logic               full;
   logic               refused;
   logic               done;
   logic               req_take;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign refused    = (func_ff == FUNC_INSERT) && !found && full;
   assign done       = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      cmd.compare    = (state_ff == ST_COMPARE);
      cmd.insert_new = done && (func_ff == FUNC_INSERT) && !found && !full;
      cmd.set_type   = done && (func_ff == FUNC_INSERT) && found;
      cmd.remove     = done && (func_ff == FUNC_EVICT) && found;
      cmd.data       = op_ff;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         entry_type left_entry;
         logic      left_lt;
         entry_type right_entry;
         if (g == 0) begin : g_first
            assign left_entry = op_ff;
            assign left_lt    = 1'b1;
         end else begin : g_left
            assign left_entry = entries[g-1];
            assign left_lt    = lt_row[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_entry = entries[g];
         end else begin : g_right
            assign right_entry = entries[g+1];
         end
         sfm_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .cell_index  (IDX_W'(g)),
            .used_count  (count_ff),
            .left_entry  (left_entry),
            .left_lt     (left_lt),
            .right_entry (right_entry),
            .entry       (entries[g]),
            .lt          (lt_row[g]),
            .eq          (eq_row[g])
         );
      end
   endgenerate

   sfm_reduce u_reduce (
      .clock    (clock),
      .enable   (state_ff == ST_REDUCE),
      .eq       (eq_row),
      .entries  (entries),
      .found    (found),
      .old_type (old_type),
      .old_size (old_size)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (done) begin
               if (cmd.insert_new) begin
                  count_in = count_ff + CNT_W'(1);
                  total_in = total_ff + TOTAL_W'(op_ff.size);
               end else if (cmd.remove) begin
                  count_in = count_ff - CNT_W'(1);
                  total_in = total_ff - TOTAL_W'(old_size);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, 7'(count_in), total_in, refused, old_type, found};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_take) begin
         func_ff         <= func_type'(req_tuser);
         op_ff.key       <= req_tdata[31:0];
         op_ff.size      <= req_tdata[63:32];
         op_ff.frag_type <= req_tdata[71:64];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
